// File: rtl/text_glyph_span_generator_top_assert.svh
// Assertion macros for the text glyph span generator.
// Used by text_glyph_span_generator_top.sv; needs a clock and an active-low reset in scope.
`ifndef TEXT_GLYPH_SPAN_GENERATOR_TOP_ASSERT_SVH
`define TEXT_GLYPH_SPAN_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/tgs_pkg.sv
// Shared types and constants of the text glyph span generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package tgs_pkg;

	localparam int COORD_BITS_DEF     = 16;
	localparam int MAX_GLYPH_ROWS_DEF = 64;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 12;
	localparam int ORIGIN_BITS    = 16;
	localparam int OUT_BITS       = 16;
	localparam int SPAN_BITS      = 7;
	localparam int ROW_BITS       = 6;
	localparam int NIBBLE_BITS    = 4;
	localparam int ATLAS_SUM_BITS = 14;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATLAS_ORIGIN_X = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATLAS_ORIGIN_Y = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_PITCH_X   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_PITCH_Y   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GLYPH_INSET_X  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GLYPH_INSET_Y  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GLYPH_W        = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GLYPH_H        = 3'd7;

	typedef struct packed {
		logic [11:0] atlas_origin_x;
		logic [11:0] atlas_origin_y;
		logic [7:0]  cell_pitch_x;
		logic [7:0]  cell_pitch_y;
		logic [7:0]  glyph_inset_x;
		logic [7:0]  glyph_inset_y;
		logic [5:0]  glyph_w;
		logic [5:0]  glyph_h;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		atlas_origin_x: 12'd0,
		atlas_origin_y: 12'd0,
		cell_pitch_x:   8'd8,
		cell_pitch_y:   8'd8,
		glyph_inset_x:  8'd0,
		glyph_inset_y:  8'd0,
		glyph_w:        6'd7,
		glyph_h:        6'd7
	};

	// glyph queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// File: rtl/tgs_fifo.sv
// Two-entry glyph request queue between front and back.
// Depends on tgs_pkg (q_stat_t).
`default_nettype none
module tgs_fifo #(
	parameter int WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output tgs_pkg::q_stat_t      stat
);
	import tgs_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/tgs_front.sv
// Front end: accepts character requests, keeps the text cursor, handles newlines
// and queues one glyph request per code other than newline. Depends on tgs_pkg.
`default_nettype none
module tgs_front #(
	parameter int COORD_BITS = tgs_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tgs_pkg::cfg_t                   cfg,
	input  wire logic                            push,
	input  wire logic [7:0]                      code,
	input  wire logic                            first,
	input  wire logic signed [tgs_pkg::ORIGIN_BITS-1:0] origin_x,
	input  wire logic signed [tgs_pkg::ORIGIN_BITS-1:0] origin_y,
	input  wire tgs_pkg::q_stat_t                q_stat,
	output logic                                 q_wr,
	output logic [4*COORD_BITS-1:0]              q_data
);
	import tgs_pkg::*;

	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic [COORD_BITS-1:0] line_start_q;

	logic                      accept;
	logic                      is_newline;
	logic [31:0]               ox_wide;
	logic [31:0]               oy_wide;
	logic [COORD_BITS-1:0]     base_x;
	logic [COORD_BITS-1:0]     base_y;
	logic [COORD_BITS-1:0]     base_ls;
	logic [NIBBLE_BITS-1:0]    cell_col;
	logic [NIBBLE_BITS-1:0]    cell_row;
	logic [ATLAS_SUM_BITS-1:0] ax_sum;
	logic [ATLAS_SUM_BITS-1:0] ay_sum;
	logic [31:0]               ax_wide;
	logic [31:0]               ay_wide;

	assign accept     = push && !q_stat.full;
	assign is_newline = (code == NEWLINE_CODE);

	// origin is sign-extended or truncated into the coordinate space
	assign ox_wide = 32'(origin_x);
	assign oy_wide = 32'(origin_y);
	assign base_x  = first ? ox_wide[COORD_BITS-1:0] : cursor_x_q;
	assign base_y  = first ? oy_wide[COORD_BITS-1:0] : cursor_y_q;
	assign base_ls = first ? ox_wide[COORD_BITS-1:0] : line_start_q;

	assign cell_col = code[NIBBLE_BITS-1:0];
	assign cell_row = code[2*NIBBLE_BITS-1:NIBBLE_BITS];
	assign ax_sum = ATLAS_SUM_BITS'(cfg.atlas_origin_x)
		+ ATLAS_SUM_BITS'(cell_col) * ATLAS_SUM_BITS'(cfg.cell_pitch_x)
		+ ATLAS_SUM_BITS'(cfg.glyph_inset_x);
	assign ay_sum = ATLAS_SUM_BITS'(cfg.atlas_origin_y)
		+ ATLAS_SUM_BITS'(cell_row) * ATLAS_SUM_BITS'(cfg.cell_pitch_y)
		+ ATLAS_SUM_BITS'(cfg.glyph_inset_y);
	assign ax_wide = 32'(ax_sum);
	assign ay_wide = 32'(ay_sum);

	assign q_wr   = accept && !is_newline;
	assign q_data = {base_x, base_y, ax_wide[COORD_BITS-1:0], ay_wide[COORD_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
		end else if (accept) begin
			line_start_q <= base_ls;
			if (is_newline) begin
				cursor_x_q <= base_ls;
				cursor_y_q <= base_y + COORD_BITS'(cfg.glyph_h);
			end else begin
				cursor_x_q <= base_x + COORD_BITS'(cfg.glyph_w);
				cursor_y_q <= base_y;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/tgs_back.sv
// Back end: takes glyph requests from the queue and emits one row span per cycle
// into the output register, unless a span waiting there is not popped. Depends on tgs_pkg.
`default_nettype none
module tgs_back #(
	parameter int COORD_BITS     = tgs_pkg::COORD_BITS_DEF,
	parameter int MAX_GLYPH_ROWS = tgs_pkg::MAX_GLYPH_ROWS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tgs_pkg::cfg_t              cfg,
	input  wire tgs_pkg::q_stat_t           q_stat,
	input  wire logic [4*COORD_BITS-1:0]    q_data,
	output logic                            q_rd,
	output logic                            busy,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [tgs_pkg::OUT_BITS-1:0]    screen_x,
	output logic [tgs_pkg::OUT_BITS-1:0]    screen_y,
	output logic [tgs_pkg::OUT_BITS-1:0]    atlas_x,
	output logic [tgs_pkg::OUT_BITS-1:0]    atlas_y,
	output logic [tgs_pkg::SPAN_BITS-1:0]   span_len,
	output logic                            last
);
	import tgs_pkg::*;

	localparam logic [ROW_BITS-1:0] ROW_LIM = ROW_BITS'(MAX_GLYPH_ROWS - 1);

	logic                  busy_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [COORD_BITS-1:0] ax_q;
	logic [COORD_BITS-1:0] ay_q;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   screen_x_q;
	logic [OUT_BITS-1:0]   screen_y_q;
	logic [OUT_BITS-1:0]   atlas_x_q;
	logic [OUT_BITS-1:0]   atlas_y_q;
	logic [SPAN_BITS-1:0]  span_len_q;
	logic                  last_q;

	logic                  advance;
	logic                  is_last;
	logic                  load;
	logic [ROW_BITS-1:0]   row_lim;
	logic [COORD_BITS-1:0] sy;
	logic [COORD_BITS-1:0] ay;
	logic [31:0]           cx_wide;
	logic [31:0]           sy_wide;
	logic [31:0]           ax_wide;
	logic [31:0]           ay_wide;

	assign row_lim = (cfg.glyph_h > ROW_LIM) ? ROW_LIM : cfg.glyph_h;
	assign advance = busy_q && (!out_valid_q || pop);
	assign is_last = (row_q == row_lim);
	// next glyph is picked up in the cycle its predecessor's last row goes out
	assign load    = (!busy_q || (advance && is_last)) && !q_stat.empty;
	assign q_rd    = load;
	assign busy    = busy_q;

	assign sy      = cy_q + COORD_BITS'(row_q);
	assign ay      = ay_q + COORD_BITS'(row_q);
	assign cx_wide = 32'(cx_q);
	assign sy_wide = 32'(sy);
	assign ax_wide = 32'(ax_q);
	assign ay_wide = 32'(ay);

	always_ff @(posedge clk) begin
		if (load) begin
			{cx_q, cy_q, ax_q, ay_q} <= q_data;
		end
		if (advance) begin
			screen_x_q <= cx_wide[OUT_BITS-1:0];
			screen_y_q <= sy_wide[OUT_BITS-1:0];
			atlas_x_q  <= ax_wide[OUT_BITS-1:0];
			atlas_y_q  <= ay_wide[OUT_BITS-1:0];
			span_len_q <= SPAN_BITS'(cfg.glyph_w) + SPAN_BITS'(1);
			last_q     <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (advance) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					row_q <= row_q + ROW_BITS'(1);
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign screen_x = screen_x_q;
	assign screen_y = screen_y_q;
	assign atlas_x  = atlas_x_q;
	assign atlas_y  = atlas_y_q;
	assign span_len = span_len_q;
	assign last     = last_q;

endmodule
`default_nettype wire

// File: rtl/text_glyph_span_generator_top.sv
// Top level of the text glyph span generator: config registers, front, queue, back.
// Depends on tgs_pkg, tgs_front, tgs_fifo, tgs_back and the assertion macro header.
//
// Each request is one character code. With first set, the cursor and the line
// start load from origin_x/origin_y before the code is handled. A newline (10)
// returns the cursor to the line start, steps it down by glyph_h and produces no
// output. Any other code selects atlas cell (code[7:4], code[3:0]) and produces
// min(glyph_h+1, MAX_GLYPH_ROWS) row spans, one per cycle from the back end's row
// counter while spans are popped, each glyph_w+1 pixels long, last set on the final
// row; the cursor then moves right by glyph_w. A newline is done in its accept cycle.
// The two-entry glyph queue lets the front keep taking requests while the back is
// still emitting, so full only rises with two glyphs queued behind the active one.
// Coordinates wrap at COORD_BITS; outputs carry their low 16 bits. Config
// registers are written with cfg_we/cfg_index/cfg_data; the user must write them
// only while idle, which the block itself does not enforce.
`default_nettype none
`include "text_glyph_span_generator_top_assert.svh"
module text_glyph_span_generator_top #(
	parameter int COORD_BITS     = tgs_pkg::COORD_BITS_DEF,
	parameter int MAX_GLYPH_ROWS = tgs_pkg::MAX_GLYPH_ROWS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// config write port
	input  wire logic                                   cfg_we,
	input  wire logic [tgs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [tgs_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	// character requests
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic [7:0]                             code,
	input  wire logic                                   first,
	input  wire logic signed [tgs_pkg::ORIGIN_BITS-1:0] origin_x,
	input  wire logic signed [tgs_pkg::ORIGIN_BITS-1:0] origin_y,
	// row spans
	output logic                                        empty,
	input  wire logic                                   pop,
	output logic signed [tgs_pkg::OUT_BITS-1:0]         screen_x,
	output logic signed [tgs_pkg::OUT_BITS-1:0]         screen_y,
	output logic [tgs_pkg::OUT_BITS-1:0]                atlas_x,
	output logic [tgs_pkg::OUT_BITS-1:0]                atlas_y,
	output logic [tgs_pkg::SPAN_BITS-1:0]               span_len,
	output logic                                        last
);
	import tgs_pkg::*;

	localparam int CMD_BITS = 4 * COORD_BITS;

	cfg_t                cfg_q;
	q_stat_t             q_stat;
	logic                q_wr;
	logic                q_rd;
	logic [CMD_BITS-1:0] q_wr_data;
	logic [CMD_BITS-1:0] q_rd_data;
	logic                back_busy;

	// config registers; all eight indexes map to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATLAS_ORIGIN_X: cfg_q.atlas_origin_x <= cfg_data[11:0];
				REG_ATLAS_ORIGIN_Y: cfg_q.atlas_origin_y <= cfg_data[11:0];
				REG_CELL_PITCH_X:   cfg_q.cell_pitch_x   <= cfg_data[7:0];
				REG_CELL_PITCH_Y:   cfg_q.cell_pitch_y   <= cfg_data[7:0];
				REG_GLYPH_INSET_X:  cfg_q.glyph_inset_x  <= cfg_data[7:0];
				REG_GLYPH_INSET_Y:  cfg_q.glyph_inset_y  <= cfg_data[7:0];
				REG_GLYPH_W:        cfg_q.glyph_w        <= cfg_data[5:0];
				REG_GLYPH_H:        cfg_q.glyph_h        <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// front holds off on a full queue, newline or not, so full never looks at code
	assign full = q_stat.full;

	tgs_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.code     (code),
		.first    (first),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.q_stat   (q_stat),
		.q_wr     (q_wr),
		.q_data   (q_wr_data)
	);

	tgs_fifo #(
		.WIDTH (CMD_BITS)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	tgs_back #(
		.COORD_BITS     (COORD_BITS),
		.MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.q_data   (q_rd_data),
		.q_rd     (q_rd),
		.busy     (back_busy),
		.empty    (empty),
		.pop      (pop),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.atlas_x  (atlas_x),
		.atlas_y  (atlas_y),
		.span_len (span_len),
		.last     (last)
	);

	// a queued glyph request is held in the queue on the next cycle
	`TGS_ASSERT_NEXT(a_glyph_queued, clk, arst_n, push && !full && code != NEWLINE_CODE, !q_stat.empty, "glyph request lost")
	// a popped row that is not the last is followed at once by the next row
	`TGS_ASSERT_NEXT(a_rows_back_to_back, clk, arst_n, pop && !empty && !last, !empty, "gap inside a glyph")
	// the back end only starts on a glyph taken from a non-empty queue
	`TGS_ASSERT_IMPL(a_start_from_queue, clk, arst_n, $rose(back_busy), $past(!q_stat.empty), "back started with no request")

endmodule
`default_nettype wire
